[hdl/hcbd_pkg.sv]
// Package for the HTTP chunked body deframer: phase and byte class codes,
// the result record and the hex digit decoder. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package hcbd_pkg;

   localparam int DEFAULT_MAX_HEX_DIGITS = 8;
   localparam int COUNT_WIDTH            = 4;
   localparam int SIZE_WIDTH             = 32;
   localparam int LEFT_WIDTH             = 33;
   localparam int TRAILER_BYTES          = 2;

   localparam logic [7:0] BYTE_CR = 8'h0D;
   localparam logic [7:0] BYTE_LF = 8'h0A;

   typedef enum logic [2:0] {
      PH_SIZE     = 3'd0,
      PH_SIZE_LF  = 3'd1,
      PH_DATA     = 3'd2,
      PH_FINAL_CR = 3'd3,
      PH_FINAL_LF = 3'd4,
      PH_ERROR    = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      CL_DIGIT    = 3'd0,
      CL_SIZECRLF = 3'd1,
      CL_PAYLOAD  = 3'd2,
      CL_TRAILER  = 3'd3,
      CL_FINAL    = 3'd4,
      CL_ERROR    = 3'd5
   } class_type;

   typedef struct packed {
      class_type   byte_class;
      logic [7:0]  payload_byte;
      logic        body_done;
      logic        error_flag;
   } result_type;

   typedef struct packed {
      logic        valid;
      logic [3:0]  value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] b);
      hex_type h;
      h.valid = 1'b1;
      h.value = 4'd0;
      if (b inside {[8'h30 : 8'h39]}) begin
         h.value = 4'(b - 8'h30);
      end else if (b inside {[8'h41 : 8'h46]}) begin
         h.value = 4'(b - 8'h41 + 8'd10);
      end else if (b inside {[8'h61 : 8'h66]}) begin
         h.value = 4'(b - 8'h61 + 8'd10);
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

endpackage

`default_nettype wire

[hdl/http_chunked_body_deframer.sv]
// Top level of the HTTP chunked body deframer: input register, framing core
// and result register with stream handshakes. Depends on hcbd_pkg, hcbd_core.
`timescale 1ns / 1ps
`default_nettype none

// Classifies a chunked HTTP/1.1 body one byte per transfer and returns one
// result per byte. A new byte is taken on every clock while the result side
// keeps up; each byte is held in the input register and is then classified
// into the result register once that register is empty or is being read.
// The framing state advances in the same cycle that a byte moves from the
// input register to the result register.
module http_chunked_body_deframer #(
   parameter int MAX_HEX_DIGITS = hcbd_pkg::DEFAULT_MAX_HEX_DIGITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] restart
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [15:0] rsp_tdata,   // [2:0] byte_class, [10:3] payload_byte, [15:11] zero
   output      logic        rsp_tlast,   // body_done
   output      logic        rsp_tuser    // [0] error_flag
);

   logic                  in_valid_ff;
   logic [7:0]            in_byte_ff;
   logic                  in_restart_ff;
   logic                  out_valid_ff;
   hcbd_pkg::result_type  out_ff;
   hcbd_pkg::result_type  result;
   logic                  step;

   assign step       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   hcbd_core #(
      .MAX_HEX_DIGITS(MAX_HEX_DIGITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .restart   (in_restart_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (step) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff    <= req_tdata;
         in_restart_ff <= req_tuser;
      end
      if (step) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_ff.payload_byte, out_ff.byte_class};
   assign rsp_tlast  = out_ff.body_done;
   assign rsp_tuser  = out_ff.error_flag;

   a_error_class : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == (out_ff.byte_class == hcbd_pkg::CL_ERROR)))
      else $error("error flag disagrees with byte class");

   a_done_final : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (out_ff.byte_class == hcbd_pkg::CL_FINAL))
      else $error("body done on a byte that is not part of the final CR LF");

   a_echo_payload : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_ff.byte_class != hcbd_pkg::CL_PAYLOAD)
         |-> (out_ff.payload_byte == 8'd0))
      else $error("payload byte echoed outside chunk data");

   a_sticky_error : assert property (@(posedge clock) disable iff (reset)
      (step && result.error_flag) |=> (step && !in_restart_ff) |-> result.error_flag)
      else $error("error state left without a restart");

endmodule

`default_nettype wire

[hdl/hcbd_core.sv]
// Framing state machine of the chunked body deframer: holds phase, size
// accumulator, digit count and remaining byte count. Depends on hcbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hcbd_core #(
   parameter int MAX_HEX_DIGITS = hcbd_pkg::DEFAULT_MAX_HEX_DIGITS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [7:0]         data_byte,
   input  wire logic               restart,
   output hcbd_pkg::result_type    result
);

   localparam logic [hcbd_pkg::COUNT_WIDTH-1:0] MaxCount =
      hcbd_pkg::COUNT_WIDTH'(MAX_HEX_DIGITS);

   hcbd_pkg::phase_type                 phase_ff, phase_in, ph;
   logic [hcbd_pkg::SIZE_WIDTH-1:0]     acc_ff, acc_in, acc;
   logic [hcbd_pkg::COUNT_WIDTH-1:0]    cnt_ff, cnt_in, cnt;
   logic [hcbd_pkg::LEFT_WIDTH-1:0]     left_ff, left_in, left;
   hcbd_pkg::hex_type                   hex;

   always_comb begin
      ph   = restart ? hcbd_pkg::PH_SIZE : phase_ff;
      acc  = restart ? '0 : acc_ff;
      cnt  = restart ? '0 : cnt_ff;
      left = restart ? '0 : left_ff;
      hex  = hcbd_pkg::hex_decode(data_byte);
   end

   always_comb begin
      phase_in = ph;
      acc_in   = acc;
      cnt_in   = cnt;
      left_in  = left;
      case (ph)
         hcbd_pkg::PH_SIZE: begin
            if (hex.valid) begin
               if (cnt >= MaxCount) begin
                  phase_in = hcbd_pkg::PH_ERROR;
               end else begin
                  acc_in = {acc[hcbd_pkg::SIZE_WIDTH-5:0], hex.value};
                  cnt_in = cnt + 1'b1;
               end
            end else if (data_byte == hcbd_pkg::BYTE_CR && cnt != '0) begin
               phase_in = hcbd_pkg::PH_SIZE_LF;
            end else begin
               phase_in = hcbd_pkg::PH_ERROR;
            end
         end
         hcbd_pkg::PH_SIZE_LF: begin
            if (data_byte == hcbd_pkg::BYTE_LF) begin
               if (acc == '0) begin
                  phase_in = hcbd_pkg::PH_FINAL_CR;
               end else begin
                  left_in  = {1'b0, acc} + hcbd_pkg::LEFT_WIDTH'(hcbd_pkg::TRAILER_BYTES);
                  phase_in = hcbd_pkg::PH_DATA;
               end
               acc_in = '0;
               cnt_in = '0;
            end else begin
               phase_in = hcbd_pkg::PH_ERROR;
            end
         end
         hcbd_pkg::PH_DATA: begin
            if (left != '0) begin
               left_in = left - 1'b1;
            end
            if (left <= hcbd_pkg::LEFT_WIDTH'(1)) begin
               phase_in = hcbd_pkg::PH_SIZE;
            end
         end
         hcbd_pkg::PH_FINAL_CR: begin
            phase_in = (data_byte == hcbd_pkg::BYTE_CR) ? hcbd_pkg::PH_FINAL_LF
                                                         : hcbd_pkg::PH_ERROR;
         end
         hcbd_pkg::PH_FINAL_LF: begin
            if (data_byte == hcbd_pkg::BYTE_LF) begin
               phase_in = hcbd_pkg::PH_SIZE;
               acc_in   = '0;
               cnt_in   = '0;
               left_in  = '0;
            end else begin
               phase_in = hcbd_pkg::PH_ERROR;
            end
         end
         default: begin
            phase_in = hcbd_pkg::PH_ERROR;
         end
      endcase
   end

   always_comb begin
      result.byte_class   = hcbd_pkg::CL_ERROR;
      result.payload_byte = 8'd0;
      result.body_done    = 1'b0;
      case (ph)
         hcbd_pkg::PH_SIZE: begin
            if (hex.valid && cnt < MaxCount) begin
               result.byte_class = hcbd_pkg::CL_DIGIT;
            end else if (!hex.valid && data_byte == hcbd_pkg::BYTE_CR && cnt != '0) begin
               result.byte_class = hcbd_pkg::CL_SIZECRLF;
            end
         end
         hcbd_pkg::PH_SIZE_LF: begin
            if (data_byte == hcbd_pkg::BYTE_LF) begin
               result.byte_class = hcbd_pkg::CL_SIZECRLF;
            end
         end
         hcbd_pkg::PH_DATA: begin
            if (left > hcbd_pkg::LEFT_WIDTH'(hcbd_pkg::TRAILER_BYTES)) begin
               result.byte_class   = hcbd_pkg::CL_PAYLOAD;
               result.payload_byte = data_byte;
            end else begin
               result.byte_class = hcbd_pkg::CL_TRAILER;
            end
         end
         hcbd_pkg::PH_FINAL_CR: begin
            if (data_byte == hcbd_pkg::BYTE_CR) begin
               result.byte_class = hcbd_pkg::CL_FINAL;
            end
         end
         hcbd_pkg::PH_FINAL_LF: begin
            if (data_byte == hcbd_pkg::BYTE_LF) begin
               result.byte_class = hcbd_pkg::CL_FINAL;
               result.body_done  = 1'b1;
            end
         end
         default: begin
            result.byte_class = hcbd_pkg::CL_ERROR;
         end
      endcase
      result.error_flag = (result.byte_class == hcbd_pkg::CL_ERROR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hcbd_pkg::PH_SIZE;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         left_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         left_ff  <= left_in;
      end
   end

endmodule

`default_nettype wire

[dv/chunk_class_checker.sv]
// Checker for the chunked body deframer: watches both stream channels, predicts
// the class of every byte taken in and compares the results. Depends on hcbd_pkg.
`timescale 1ns / 1ps

module chunk_class_checker #(
   parameter int MAX_HEX_DIGITS = hcbd_pkg::DEFAULT_MAX_HEX_DIGITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] restart
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [15:0] rsp_tdata,   // [2:0] byte_class, [10:3] payload_byte, [15:11] zero
   input  wire logic        rsp_tlast,   // body_done
   input  wire logic        rsp_tuser,   // [0] error_flag
   output int               error_count,
   output int               pending_count
);

   import hcbd_pkg::*;

   phase_type   frame_phase;
   logic [31:0] size_value;
   logic [3:0]  digits_seen;
   logic [32:0] bytes_to_go;
   result_type  expected_classes[$];

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   function automatic void clear_framing();
      frame_phase = PH_SIZE;
      size_value  = '0;
      digits_seen = '0;
      bytes_to_go = '0;
   endfunction

   function automatic result_type classify_byte(input logic [7:0] b, input logic restart);
      result_type res;
      logic       is_hex;
      logic [3:0] nibble;
      res.byte_class   = CL_ERROR;
      res.payload_byte = 8'h00;
      res.body_done    = 1'b0;
      is_hex = 1'b1;
      nibble = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         nibble = 4'(b - 8'h30);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         nibble = 4'(b - 8'h37);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         nibble = 4'(b - 8'h57);
      end else begin
         is_hex = 1'b0;
      end
      if (restart) begin
         clear_framing();
      end
      case (frame_phase)
         PH_SIZE: begin
            if (is_hex) begin
               if (int'(digits_seen) >= MAX_HEX_DIGITS) begin
                  frame_phase = PH_ERROR;
               end else begin
                  size_value     = {size_value[27:0], nibble};
                  digits_seen    = digits_seen + 4'd1;
                  res.byte_class = CL_DIGIT;
               end
            end else if (b == BYTE_CR && digits_seen != 4'd0) begin
               frame_phase    = PH_SIZE_LF;
               res.byte_class = CL_SIZECRLF;
            end else begin
               frame_phase = PH_ERROR;
            end
         end
         PH_SIZE_LF: begin
            if (b == BYTE_LF) begin
               res.byte_class = CL_SIZECRLF;
               if (size_value == 32'd0) begin
                  frame_phase = PH_FINAL_CR;
               end else begin
                  bytes_to_go = {1'b0, size_value} + 33'(TRAILER_BYTES);
                  frame_phase = PH_DATA;
               end
               size_value  = '0;
               digits_seen = '0;
            end else begin
               frame_phase = PH_ERROR;
            end
         end
         PH_DATA: begin
            if (bytes_to_go > 33'(TRAILER_BYTES)) begin
               res.byte_class   = CL_PAYLOAD;
               res.payload_byte = b;
            end else begin
               res.byte_class = CL_TRAILER;
            end
            if (bytes_to_go != '0) begin
               bytes_to_go = bytes_to_go - 33'd1;
            end
            if (bytes_to_go == '0) begin
               frame_phase = PH_SIZE;
            end
         end
         PH_FINAL_CR: begin
            if (b == BYTE_CR) begin
               res.byte_class = CL_FINAL;
               frame_phase    = PH_FINAL_LF;
            end else begin
               frame_phase = PH_ERROR;
            end
         end
         PH_FINAL_LF: begin
            if (b == BYTE_LF) begin
               res.byte_class = CL_FINAL;
               res.body_done  = 1'b1;
               clear_framing();
            end else begin
               frame_phase = PH_ERROR;
            end
         end
         default: begin
            frame_phase = PH_ERROR;
         end
      endcase
      res.error_flag = (res.byte_class == CL_ERROR);
      return res;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         clear_framing();
         expected_classes.delete();
         pending_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_classes.size() == 0) begin
               if (error_count < 10) begin
                  $display("result transfer with no byte outstanding: tdata %04h last %0b user %0b",
                           rsp_tdata, rsp_tlast, rsp_tuser);
               end
               error_count = error_count + 1;
            end else begin
               want = expected_classes.pop_front();
               if (rsp_tdata[2:0] != want.byte_class || rsp_tdata[10:3] != want.payload_byte
                   || rsp_tdata[15:11] != 5'd0 || rsp_tlast != want.body_done
                   || rsp_tuser != want.error_flag) begin
                  if (error_count < 10) begin
                     $write("result mismatch (expected/actual): class %0d/%0d payload %02h/%02h",
                            want.byte_class, rsp_tdata[2:0], want.payload_byte, rsp_tdata[10:3]);
                     $display(" done %0b/%0b error %0b/%0b pad 0/%0h",
                              want.body_done, rsp_tlast, want.error_flag, rsp_tuser,
                              rsp_tdata[15:11]);
                  end
                  error_count = error_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_classes.push_back(classify_byte(req_tdata, req_tuser));
         end
         pending_count = expected_classes.size();
      end
   end

endmodule

[dv/http_chunked_body_deframer_test.sv]
// Testbench top for the chunked body deframer: feeds directed and random chunked
// bodies with random idling and gives the verdict. Depends on hcbd_pkg,
// chunk_class_checker and the deframer RTL.
`timescale 1ns / 1ps

module http_chunked_body_deframer_test;

   import hcbd_pkg::*;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   int   checker_errors;
   int   checker_pending;
   int   items_sent        = 0;
   int   req_gap_max       = 9;
   int   corrupt_countdown = 0;
   int   rsp_stall         = 0;
   logic restart_pending   = 1'b0;
   logic rsp_calm          = 1'b0;

   always #1 clock = ~clock;

   http_chunked_body_deframer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   chunk_class_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tuser     (rsp_tuser),
      .error_count   (checker_errors),
      .pending_count (checker_pending)
   );

   // The receiver drops ready for a random stall after each result transfer; with rsp_calm set it does not stall.
   always @(posedge clock) begin
      int stall;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         stall = rsp_calm ? 0 : $urandom_range(0, 9);
         rsp_tready <= (stall == 0);
         rsp_stall  <= stall;
      end else if (rsp_stall > 0) begin
         rsp_tready <= (rsp_stall == 1);
         rsp_stall  <= rsp_stall - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) begin
         return 8'h30 + 8'(v);
      end
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic restart);
      int         gap;
      logic [7:0] d;
      gap = $urandom_range(0, req_gap_max);
      d = b;
      if (corrupt_countdown == 1) begin
         d = 8'($urandom_range(0, 255));
      end
      if (corrupt_countdown > 0) begin
         corrupt_countdown = corrupt_countdown - 1;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= restart | restart_pending;
      restart_pending = 1'b0;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent = items_sent + 1;
   endtask

   task automatic send_size_line(input logic [31:0] value, input int ndig);
      for (int i = ndig - 1; i >= 0; i--) begin
         send_byte(hex_char(value[4*i +: 4]), 1'b0);
      end
      send_byte(BYTE_CR, 1'b0);
      send_byte(BYTE_LF, 1'b0);
   endtask

   task automatic send_body();
      int chunks;
      int size;
      int need;
      int ndig;
      chunks = $urandom_range(0, 3);
      repeat (chunks) begin
         size = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         need = (size > 15) ? 2 : 1;
         ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(need, 8) : need;
         send_size_line(32'(size), ndig);
         repeat (size) send_byte(8'($urandom_range(0, 255)), 1'b0);
         if ($urandom_range(0, 3) == 0) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b0);
         end else begin
            send_byte(BYTE_CR, 1'b0);
            send_byte(BYTE_LF, 1'b0);
         end
      end
      send_size_line(32'd0, $urandom_range(1, 3));
      send_byte(BYTE_CR, 1'b0);
      send_byte(BYTE_LF, 1'b0);
   endtask

   initial begin
      int          pick;
      logic [31:0] huge;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: a full body, then faults in the size line, all but the first after a restart.
      send_byte(8'h32, 1'b0);
      send_byte(BYTE_CR, 1'b0);
      send_byte(BYTE_LF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(BYTE_CR, 1'b0);
      send_byte(BYTE_LF, 1'b0);
      send_byte(8'h30, 1'b0);
      send_byte(BYTE_CR, 1'b0);
      send_byte(BYTE_LF, 1'b0);
      send_byte(BYTE_CR, 1'b0);
      send_byte(BYTE_LF, 1'b0);
      send_byte(BYTE_CR, 1'b0);
      send_byte(8'h67, 1'b1);
      send_byte(8'h41, 1'b0);
      send_byte(8'h31, 1'b1);
      send_byte(BYTE_CR, 1'b0);
      send_byte(8'h58, 1'b0);
      send_byte(8'h30, 1'b1);
      send_byte(BYTE_CR, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_byte(8'h66, 1'b1);
      repeat (7) send_byte(8'h46, 1'b0);
      send_byte(8'h39, 1'b0);
      restart_pending = 1'b1;

      while (items_sent < 530) begin
         req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
         rsp_calm <= ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 7) == 0) begin
            restart_pending = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            if (pick < 12) begin
               corrupt_countdown = $urandom_range(1, 30);
            end
            send_body();
            if (pick < 12) begin
               corrupt_countdown = 0;
               restart_pending = 1'b1;
            end
         end else if (pick < 80) begin
            huge = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h0100_0000);
            send_size_line(huge, 8);
            repeat ($urandom_range(0, 10)) send_byte(8'($urandom_range(0, 255)), 1'b0);
            restart_pending = 1'b1;
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 8)) begin
               send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
            end
            restart_pending = 1'b1;
         end else begin
            repeat ($urandom_range(9, 11)) send_byte(hex_char(4'($urandom_range(0, 15))), 1'b0);
            restart_pending = 1'b1;
         end
      end
      req_tvalid <= 1'b0;
      rsp_calm <= 1'b0;

      @(negedge clock);
      while (checker_pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (checker_errors == 0 && checker_pending == 0) begin
         $display("http_chunked_body_deframer_test: done, clean");
      end else begin
         $display("http_chunked_body_deframer_test: done, errors");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("http_chunked_body_deframer_test: done, errors");
      $finish;
   end

endmodule
